FILE: rtl/ghl_pkg.sv
// ----------------------------------------------------------------------------
// ghl_pkg
// shared types and constants of the grid histogram localizer
// ----------------------------------------------------------------------------
`default_nettype none

package ghl_pkg;

    // probabilities are q16, 65536 is one
    localparam int          PROB_W  = 17;
    localparam int          PIECE_W = 33;
    localparam int          ONE_INT = 65536;
    localparam logic [16:0] ONE     = 17'h10000;

    // opcodes
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_UNIFORM = 2'd1;
    localparam logic [1:0] OP_STEP    = 2'd2;
    localparam logic [1:0] OP_SPARE   = 2'd3;

    // register indexes
    localparam logic REG_CORRECT = 1'b0;
    localparam logic REG_MOVE    = 1'b1;

    localparam logic [16:0] CORRECT_RST = 17'd45875;
    localparam logic [16:0] MOVE_RST    = 17'd52429;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [2:0]        cell_row;
        logic [2:0]        cell_col;
        logic [7:0]        cell_color;
        logic signed [3:0] motion_row;
        logic signed [3:0] motion_col;
        logic [7:0]        measurement;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  out_row;
        logic [2:0]  out_col;
        logic [16:0] cell_prob;
        logic        degenerate;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic take;
        logic init_step;
        logic a_own;
        logic a_src;
        logic a_mix;
        logic a_piece;
        logic a_acc;
        logic b_rd;
        logic b_piece;
        logic b_div;
        logic b_out;
        logic b_next;
    } t_cmd;

    typedef struct packed {
        logic is_step;
        logic init_done;
        logic cell_last;
        logic div_done;
        logic out_busy;
    } t_sts;

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_INIT = 14'b00000000000010,
        S_A0   = 14'b00000000000100,
        S_A1   = 14'b00000000001000,
        S_A2   = 14'b00000000010000,
        S_A3   = 14'b00000000100000,
        S_A4   = 14'b00000001000000,
        S_A5   = 14'b00000010000000,
        S_B0   = 14'b00000100000000,
        S_B1   = 14'b00001000000000,
        S_B2   = 14'b00010000000000,
        S_B3   = 14'b00100000000000,
        S_B4   = 14'b01000000000000,
        S_B5   = 14'b10000000000000
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/ghl_if.sv
// ----------------------------------------------------------------------------
// ghl_if
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
`default_nettype none

interface ghl_in_if;
    logic              valid;
    logic              ready;
    ghl_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ghl_out_if;
    logic               valid;
    logic               ready;
    ghl_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/ghl_ram.sv
// ----------------------------------------------------------------------------
// ghl_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module ghl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 20,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [AW-1:0]        i_waddr,
    input  wire logic [WIDTH-1:0]     i_wdata,
    input  wire logic [AW-1:0]        i_raddr,
    output logic      [WIDTH-1:0]     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

FILE: rtl/ghl_div.sv
// ----------------------------------------------------------------------------
// ghl_div
// restoring divider, one quotient bit a cycle: floor(num * 65536 / den)
// ----------------------------------------------------------------------------
`default_nettype none

module ghl_div #(
    parameter int SW = 38
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [ghl_pkg::PIECE_W-1:0]   i_num,
    input  wire logic [SW-1:0]                 i_den,
    output logic                               o_busy,
    output logic [ghl_pkg::PROB_W-1:0]         o_quo
);
    logic [SW-1:0] r_rem;
    logic          r_lsb;
    logic [4:0]    r_cnt;
    logic [SW:0]   w_trial;
    logic          w_fit;

    // num <= den, so num/2 < den and 17 quotient bits cover the result
    assign w_trial = {r_rem, r_lsb};
    assign w_fit   = (w_trial >= {1'b0, i_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            o_busy <= 1'b1;
            r_cnt  <= 5'(ghl_pkg::PROB_W);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                o_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= SW'(i_num[ghl_pkg::PIECE_W-1:1]);
            r_lsb <= i_num[0];
            o_quo <= '0;
        end else if (o_busy) begin
            r_rem <= w_fit ? SW'(w_trial - {1'b0, i_den}) : w_trial[SW-1:0];
            r_lsb <= 1'b0;
            o_quo <= {o_quo[ghl_pkg::PROB_W-2:0], w_fit};
        end
    end
endmodule

`default_nettype wire

FILE: rtl/ghl_ctrl.sv
// ----------------------------------------------------------------------------
// ghl_ctrl
// sequencer of the localizer: motion pass, then sense and normalize pass
// ----------------------------------------------------------------------------
`default_nettype none

module ghl_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire ghl_pkg::t_sts i_sts,
    output logic               o_in_ready,
    output ghl_pkg::t_cmd      o_cmd
);
    ghl_pkg::t_state r_state, n_state;

    assign o_in_ready = (r_state == ghl_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ghl_pkg::S_IDLE: begin
                if (i_in_valid && i_sts.is_step) begin
                    n_state = ghl_pkg::S_INIT;
                end
            end
            ghl_pkg::S_INIT: begin
                if (i_sts.init_done) begin
                    n_state = ghl_pkg::S_A0;
                end
            end
            ghl_pkg::S_A0: n_state = ghl_pkg::S_A1;
            ghl_pkg::S_A1: n_state = ghl_pkg::S_A2;
            ghl_pkg::S_A2: n_state = ghl_pkg::S_A3;
            ghl_pkg::S_A3: n_state = ghl_pkg::S_A4;
            ghl_pkg::S_A4: n_state = ghl_pkg::S_A5;
            ghl_pkg::S_A5: n_state = i_sts.cell_last ? ghl_pkg::S_B0 : ghl_pkg::S_A0;
            ghl_pkg::S_B0: n_state = ghl_pkg::S_B1;
            ghl_pkg::S_B1: n_state = ghl_pkg::S_B2;
            ghl_pkg::S_B2: n_state = ghl_pkg::S_B3;
            ghl_pkg::S_B3: begin
                if (i_sts.div_done && !i_sts.out_busy) begin
                    n_state = ghl_pkg::S_B4;
                end
            end
            ghl_pkg::S_B4: n_state = ghl_pkg::S_B5;
            ghl_pkg::S_B5: n_state = i_sts.cell_last ? ghl_pkg::S_IDLE : ghl_pkg::S_B0;
            default:       n_state = ghl_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.take      = (r_state == ghl_pkg::S_IDLE) && i_in_valid;
        o_cmd.init_step = (r_state == ghl_pkg::S_INIT);
        o_cmd.a_own     = (r_state == ghl_pkg::S_A0);
        o_cmd.a_src     = (r_state == ghl_pkg::S_A1);
        o_cmd.a_mix     = (r_state == ghl_pkg::S_A3);
        o_cmd.a_piece   = (r_state == ghl_pkg::S_A4);
        o_cmd.a_acc     = (r_state == ghl_pkg::S_A5);
        o_cmd.b_rd      = (r_state == ghl_pkg::S_B0);
        o_cmd.b_piece   = (r_state == ghl_pkg::S_B1);
        o_cmd.b_div     = (r_state == ghl_pkg::S_B2);
        o_cmd.b_out     = (r_state == ghl_pkg::S_B4);
        o_cmd.b_next    = (r_state == ghl_pkg::S_B5);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ghl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

`default_nettype wire

FILE: rtl/ghl_dp.sv
// ----------------------------------------------------------------------------
// ghl_dp
// datapath: grid stores, cell counters, mixing and weighting, normalizer
// ----------------------------------------------------------------------------
`default_nettype none

module ghl_dp #(
    parameter int ROWS = 4,
    parameter int COLS = 5
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire ghl_pkg::t_cmd          i_cmd,
    output ghl_pkg::t_sts               o_sts,
    input  wire ghl_pkg::t_in_item      i_item,
    input  wire logic [16:0]            i_correct,
    input  wire logic [16:0]            i_move,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output ghl_pkg::t_out_item          o_out
);
    localparam int          CELLS = ROWS * COLS;
    localparam int          AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int          SW    = ghl_pkg::PIECE_W + AW;
    localparam logic [16:0] UNI   = 17'(ghl_pkg::ONE_INT / CELLS);
    localparam logic [2:0]  LROW  = 3'(ROWS - 1);
    localparam logic [2:0]  LCOL  = 3'(COLS - 1);

    // cell walk
    logic [2:0]        r_row, r_col, r_sr, r_sc, r_sc0;
    logic [AW-1:0]     r_idx;
    logic signed [3:0] r_dr, r_dc;
    logic [AW-1:0]     w_src;
    logic              w_last;

    // step data
    logic [7:0]         r_meas;
    logic               r_uniform;
    logic               r_match;
    logic [32:0]        r_p0, r_p1;
    logic [16:0]        r_scr;
    logic [32:0]        r_piece;
    logic [SW-1:0]      r_sum;

    logic [16:0] w_stay, w_wneg;
    logic [16:0] w_prob_q, w_scr_q, w_pv;
    logic [7:0]  w_color_q;
    logic [33:0] w_mul_a, w_mul_b;
    logic [33:0] w_mix_sum;
    logic [16:0] w_mix;
    logic [16:0] w_wa, w_wb;
    logic [16:0] w_quo, w_res;
    logic        w_div_busy, w_degen;

    logic           w_load_ok;
    logic [5:0]     w_load_lin;
    logic [AW-1:0]  w_prob_raddr;

    assign w_last = (r_idx == AW'(CELLS - 1));
    assign w_src  = AW'(AW'(r_sr) * AW'(COLS)) + AW'(r_sc);

    assign w_stay = ghl_pkg::ONE - i_move;
    assign w_wneg = ghl_pkg::ONE - i_correct;
    assign w_pv   = r_uniform ? UNI : w_prob_q;
    assign w_degen = (r_sum == '0);

    // color writes outside the grid are dropped
    assign w_load_ok  = i_cmd.take && (i_item.opcode == ghl_pkg::OP_LOAD)
                     && (4'(i_item.cell_row) < 4'(ROWS))
                     && (4'(i_item.cell_col) < 4'(COLS));
    assign w_load_lin = 6'(i_item.cell_row) * 6'(COLS) + 6'(i_item.cell_col);

    assign w_prob_raddr = i_cmd.a_src ? w_src : r_idx;

    ghl_ram #(.WIDTH(17), .DEPTH(CELLS)) u_prob_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.b_out),
        .i_waddr (r_idx),
        .i_wdata (w_res),
        .i_raddr (w_prob_raddr),
        .o_rdata (w_prob_q)
    );

    ghl_ram #(.WIDTH(17), .DEPTH(CELLS)) u_scratch_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.a_mix),
        .i_waddr (r_idx),
        .i_wdata (w_mix),
        .i_raddr (r_idx),
        .o_rdata (w_scr_q)
    );

    ghl_ram #(.WIDTH(8), .DEPTH(CELLS)) u_color_ram (
        .i_clk   (i_clk),
        .i_we    (w_load_ok),
        .i_waddr (AW'(w_load_lin)),
        .i_wdata (i_item.cell_color),
        .i_raddr (r_idx),
        .o_rdata (w_color_q)
    );

    // separate weighting multiplier for each pass: w_mul_a in the motion pass, w_mul_b in the sense pass
    assign w_wa      = r_match ? i_correct : w_wneg;
    assign w_mul_a   = 34'(w_wa) * 34'(r_scr);
    assign w_wb      = (w_color_q == r_meas) ? i_correct : w_wneg;
    assign w_mul_b   = 34'(w_wb) * 34'(w_scr_q);
    assign w_mix_sum = 34'(r_p0) + 34'(r_p1);
    assign w_mix     = (w_mix_sum[33:16] > 18'(ghl_pkg::ONE)) ? ghl_pkg::ONE
                                                              : w_mix_sum[32:16];

    ghl_div #(.SW(SW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.b_div),
        .i_num   (r_piece),
        .i_den   (r_sum),
        .o_busy  (w_div_busy),
        .o_quo   (w_quo)
    );

    // a zero normalizer leaves every piece at zero
    assign w_res = w_degen ? r_piece[32:16] : w_quo;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_meas <= i_item.measurement;
        end
        if (i_cmd.a_own) begin
            r_match <= (w_color_q == r_meas);
        end
        if (i_cmd.a_src) begin
            r_p0    <= 33'(34'(w_stay) * 34'(w_pv));
            r_match <= (w_color_q == r_meas);
        end
        if (i_cmd.a_mix) begin
            r_scr <= w_mix;
        end
        if (i_cmd.a_piece) begin
            r_piece <= 33'(w_mul_a);
        end
        if (i_cmd.b_piece) begin
            r_piece <= 33'(w_mul_b);
        end
    end

    // src product in the cycle after the own product
    logic r_src_phase;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_phase <= 1'b0;
        end else begin
            r_src_phase <= i_cmd.a_src;
        end
    end
    always_ff @(posedge i_clk) begin
        if (r_src_phase) begin
            r_p1 <= 33'(34'(i_move) * 34'(w_pv));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uniform <= 1'b1;
            r_sum     <= '0;
        end else begin
            if (i_cmd.take && (i_item.opcode == ghl_pkg::OP_UNIFORM)) begin
                r_uniform <= 1'b1;
            end else if (i_cmd.a_acc && w_last) begin
                r_uniform <= 1'b0;
            end
            if (i_cmd.take) begin
                r_sum <= '0;
            end else if (i_cmd.a_acc) begin
                r_sum <= r_sum + SW'(r_piece);
            end
        end
    end

    // cell counters; source row and column trail by the motion with wrap-around
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_idx <= '0;
            r_sr  <= '0;
            r_sc  <= '0;
            r_sc0 <= '0;
            r_dr  <= '0;
            r_dc  <= '0;
        end else if (i_cmd.take) begin
            r_row <= '0;
            r_col <= '0;
            r_idx <= '0;
            r_sr  <= '0;
            r_sc  <= '0;
            r_sc0 <= '0;
            r_dr  <= i_item.motion_row;
            r_dc  <= i_item.motion_col;
        end else if (i_cmd.init_step) begin
            if (r_dr > 4'sd0) begin
                r_sr <= (r_sr == 3'd0) ? LROW : r_sr - 3'd1;
                r_dr <= r_dr - 4'sd1;
            end else if (r_dr < 4'sd0) begin
                r_sr <= (r_sr == LROW) ? 3'd0 : r_sr + 3'd1;
                r_dr <= r_dr + 4'sd1;
            end
            if (r_dc > 4'sd0) begin
                r_sc  <= (r_sc == 3'd0) ? LCOL : r_sc - 3'd1;
                r_sc0 <= (r_sc == 3'd0) ? LCOL : r_sc - 3'd1;
                r_dc  <= r_dc - 4'sd1;
            end else if (r_dc < 4'sd0) begin
                r_sc  <= (r_sc == LCOL) ? 3'd0 : r_sc + 3'd1;
                r_sc0 <= (r_sc == LCOL) ? 3'd0 : r_sc + 3'd1;
                r_dc  <= r_dc + 4'sd1;
            end
        end else if (i_cmd.a_acc || i_cmd.b_next) begin
            if (w_last) begin
                r_row <= '0;
                r_col <= '0;
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + AW'(1);
                if (r_col == LCOL) begin
                    r_col <= '0;
                    r_row <= r_row + 3'd1;
                    r_sc  <= r_sc0;
                    r_sr  <= (r_sr == LROW) ? 3'd0 : r_sr + 3'd1;
                end else begin
                    r_col <= r_col + 3'd1;
                    r_sc  <= (r_sc == LCOL) ? 3'd0 : r_sc + 3'd1;
                end
            end
        end
    end

    // result register parts the sequencer from the sink
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.b_out) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.b_out) begin
            o_out.out_row    <= r_row;
            o_out.out_col    <= r_col;
            o_out.cell_prob  <= w_res;
            o_out.degenerate <= w_degen;
            o_out.last       <= w_last;
        end
    end

    always_comb begin
        o_sts           = '0;
        o_sts.is_step   = (i_item.opcode == ghl_pkg::OP_STEP);
        o_sts.init_done = (r_dr == 4'sd0) && (r_dc == 4'sd0);
        o_sts.cell_last = w_last;
        o_sts.div_done  = !w_div_busy;
        o_sts.out_busy  = o_out_valid || i_cmd.b_rd;
    end
endmodule

`default_nettype wire

FILE: rtl/grid_histogram_localizer.sv
// ----------------------------------------------------------------------------
// grid_histogram_localizer
// discrete bayes filter over a cyclic ROWS x COLS grid of q16 probabilities
// ----------------------------------------------------------------------------
// One item is handled at a time. A load or a uniform-reset item is taken
// while idle and starts no pass. A step item first sets up the motion offset,
// then runs the motion pass cell by cell (two reads of the one read port of
// the probability store, two registered multiplies, the weighting multiply and
// the accumulate), then the sense pass cell by cell, which waits on the
// bit-serial divider used for normalization. A stalled sink holds the pass.
// Results leave in row-major order through an output register, one beat per
// cell, with last set on the final cell. There is no clearing pass after reset:
// the uniform grid is held as a flag until the first step writes every cell.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_histogram_localizer #(
    parameter int ROWS = 4,
    parameter int COLS = 5
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // item channels
    ghl_in_if.sink           i_in,
    ghl_out_if.source        o_out
);
    // configuration registers
    logic [16:0] r_correct, r_move;
    logic [16:0] w_correct, w_move;
    logic        w_cfg_wr;

    ghl_pkg::t_cmd w_cmd;
    ghl_pkg::t_sts w_sts;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_correct <= ghl_pkg::CORRECT_RST;
            r_move    <= ghl_pkg::MOVE_RST;
        end else if (w_cfg_wr) begin
            if (paddr[2] == ghl_pkg::REG_CORRECT) begin
                r_correct <= pwdata[16:0];
            end else begin
                r_move <= pwdata[16:0];
            end
        end
    end

    // read back the raw register value
    assign prdata = (paddr[2] == ghl_pkg::REG_MOVE) ? 32'(r_move) : 32'(r_correct);

    // values above one act as one
    assign w_correct = (r_correct > ghl_pkg::ONE) ? ghl_pkg::ONE : r_correct;
    assign w_move    = (r_move > ghl_pkg::ONE) ? ghl_pkg::ONE : r_move;

    // sequencer
    ghl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (w_sts),
        .o_in_ready (i_in.ready),
        .o_cmd      (w_cmd)
    );

    // grid stores, arithmetic and the result register
    ghl_dp #(.ROWS(ROWS), .COLS(COLS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_item      (i_in.data),
        .i_correct   (w_correct),
        .i_move      (w_move),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out       (o_out.data)
    );

`ifndef SYNTH
    // the final beat of a step is always the bottom-right cell
    a_last_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.last |->
            (o_out.data.out_row == 3'(ROWS - 1)) && (o_out.data.out_col == 3'(COLS - 1)))
        else $error("last beat not on final cell");

    // a result is only loaded into a free output register
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.b_out |-> !o_out.valid)
        else $error("result register overwritten");

    // no new item is taken while a result is being produced
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.b_out |-> !i_in.ready)
        else $error("input ready during sense pass");
`endif
endmodule

`default_nettype wire

FILE: tb/sv/ghl_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ghl_checker
// watches the item channels and register port, predicts each step's cells
// ----------------------------------------------------------------------------
// Keeps its own copy of the probability grid, the color map and the two
// registers. Every accepted step beat expands into one expected cell per grid
// position. These are compared, field by field, against the result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module ghl_checker #(
    parameter int ROWS = 4,
    parameter int COLS = 5
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire ghl_pkg::t_in_item  i_in_data,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire ghl_pkg::t_out_item i_out_data,
    output int               o_errors,
    output int               o_pending
);
    localparam int CELLS = ROWS * COLS;

    logic [16:0]        correct_reg;
    logic [16:0]        move_reg;
    logic [16:0]        belief [CELLS];
    logic [7:0]         colors [CELLS];
    ghl_pkg::t_out_item cells_due [$];

    function automatic logic [16:0] sat_one(logic [63:0] v);
        return (v > 64'd65536) ? ghl_pkg::ONE : v[16:0];
    endfunction

    function automatic int modn(int v, int n);
        int r;
        r = v % n;
        return (r < 0) ? r + n : r;
    endfunction

    // motion then sense update, pushes one expectation per cell
    task automatic predict_step(ghl_pkg::t_in_item it);
        logic [63:0] mv;
        logic [63:0] stay;
        logic [63:0] c;
        logic [63:0] w;
        logic [63:0] acc;
        logic [63:0] sum;
        logic [63:0] piece [CELLS];
        logic [16:0] moved [CELLS];
        ghl_pkg::t_out_item o;
        int          dr;
        int          dc;
        int          src;
        mv   = sat_one(64'(move_reg));
        stay = 64'd65536 - mv;
        dr   = int'(it.motion_row);
        dc   = int'(it.motion_col);
        for (int r = 0; r < ROWS; r++) begin
            for (int k = 0; k < COLS; k++) begin
                src = modn(r - dr, ROWS) * COLS + modn(k - dc, COLS);
                acc = stay * belief[r * COLS + k] + mv * belief[src];
                moved[r * COLS + k] = sat_one(acc >> 16);
            end
        end
        c   = sat_one(64'(correct_reg));
        sum = 0;
        for (int i = 0; i < CELLS; i++) begin
            w = (colors[i] == it.measurement) ? c : 64'd65536 - c;
            piece[i] = w * moved[i];
            sum += piece[i];
        end
        for (int i = 0; i < CELLS; i++) begin
            if (sum == 0) begin
                belief[i] = sat_one(piece[i] >> 16);
            end else begin
                belief[i] = sat_one((piece[i] << 16) / sum);
            end
            o.out_row    = 3'(i / COLS);
            o.out_col    = 3'(i % COLS);
            o.cell_prob  = belief[i];
            o.degenerate = (sum == 0);
            o.last       = (i == CELLS - 1);
            cells_due.push_back(o);
        end
    endtask

    always @(posedge i_clk) begin
        ghl_pkg::t_out_item exp_cell;
        if (!i_rst_n) begin
            correct_reg = ghl_pkg::CORRECT_RST;
            move_reg    = ghl_pkg::MOVE_RST;
            for (int i = 0; i < CELLS; i++) begin
                belief[i] = 17'(65536 / CELLS);
                colors[i] = '0;
            end
            cells_due.delete();
            o_errors <= 0;
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == ghl_pkg::REG_MOVE) begin
                    move_reg = pwdata[16:0];
                end else begin
                    correct_reg = pwdata[16:0];
                end
            end
            // result beats against oldest expectation
            if (i_out_valid && i_out_ready) begin
                if (cells_due.size() == 0) begin
                    $display("%0t: unexpected cell beat %p", $time, i_out_data);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_cell = cells_due.pop_front();
                    if (exp_cell !== i_out_data) begin
                        $display("%0t: cell mismatch expected %p actual %p",
                                 $time, exp_cell, i_out_data);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            // input beats update the model
            if (i_in_valid && i_in_ready) begin
                case (i_in_data.opcode)
                    ghl_pkg::OP_LOAD: begin
                        if (i_in_data.cell_row < ROWS && i_in_data.cell_col < COLS)
                            colors[i_in_data.cell_row * COLS + i_in_data.cell_col] =
                                i_in_data.cell_color;
                    end
                    ghl_pkg::OP_UNIFORM: begin
                        for (int i = 0; i < CELLS; i++) belief[i] = 17'(65536 / CELLS);
                    end
                    ghl_pkg::OP_STEP: begin
                        predict_step(i_in_data);
                    end
                    default: ;
                endcase
            end
        end
        o_pending <= cells_due.size();
    end

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the grid histogram localizer
// ----------------------------------------------------------------------------
// Loads a full color map, runs directed steps over the motion and register
// extremes, then random phases of loads, resets and steps under bursty input
// and a stalling sink. The checker beside the block does all comparison.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    localparam int ROWS  = 4;
    localparam int COLS  = 5;
    localparam int CELLS = ROWS * COLS;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          pending;
    int          cycles = 0;
    // long sink hold-off request from the stimulus process
    logic        hold_sink = 1'b0;

    ghl_in_if  in_ch ();
    ghl_out_if out_ch ();

    always #6 i_clk = ~i_clk;

    grid_histogram_localizer #(.ROWS(ROWS), .COLS(COLS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    ghl_checker #(.ROWS(ROWS), .COLS(COLS)) checker_u (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .i_in_valid(in_ch.valid), .i_in_ready(in_ch.ready), .i_in_data(in_ch.data),
        .i_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_out_data(out_ch.data),
        .o_errors(errors), .o_pending(pending)
    );

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // sink stalls: randomly chosen modes, plus one long hold-off counted here
    initial begin
        int mode;
        int span;
        bit hold_done;
        hold_done = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(5, 120);
            if (hold_sink && !hold_done) begin
                hold_done = 1'b1;
                mode = 3;
                span = HOLD_CYCLES;
            end
            repeat (span) begin
                @(posedge i_clk);
                if (mode == 3) out_ch.ready <= 1'b0;
                else if (mode == 0) out_ch.ready <= 1'b1;
                else if (mode == 1) out_ch.ready <= ($urandom_range(0, 3) != 0);
                else out_ch.ready <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    // two-phase register write
    task automatic write_reg(logic idx, logic [16:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {15'h0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    int burst_left = 0;

    // offer one beat, keeping valid up across back-to-back beats
    task automatic send_item(ghl_pkg::t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        burst_left--;
    endtask

    // let every expected cell arrive, then a short tail
    task automatic drain;
        in_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0 || in_ch.valid);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic ghl_pkg::t_in_item random_noise();
        ghl_pkg::t_in_item it;
        it = ghl_pkg::t_in_item'($urandom);
        it.cell_color = 8'($urandom);
        return it;
    endfunction

    function automatic ghl_pkg::t_in_item make_load(int r, int c, logic [7:0] color);
        ghl_pkg::t_in_item it;
        it = '0;
        it.opcode     = ghl_pkg::OP_LOAD;
        it.cell_row   = 3'(r);
        it.cell_col   = 3'(c);
        it.cell_color = color;
        return it;
    endfunction

    function automatic ghl_pkg::t_in_item make_step(logic [3:0] dr, logic [3:0] dc,
                                                    logic [7:0] meas);
        ghl_pkg::t_in_item it;
        it = random_noise();
        it.opcode      = ghl_pkg::OP_STEP;
        it.motion_row  = dr;
        it.motion_col  = dc;
        it.measurement = meas;
        return it;
    endfunction

    initial begin
        ghl_pkg::t_in_item it;
        logic [16:0]       reg_set [6];
        int                pick;
        reg_set = '{17'd0, 17'd65536, 17'h1FFFF, 17'd32768, 17'd45875, 17'd1};
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // color map with two palette values so measurements match often
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
                send_item(make_load(r, c, ((r + c) % 2) ? 8'hFF : 8'h00));
            end
        end
        // directed: motion extremes, measurement match and miss, reset items
        send_item(make_step(4'sd0, 4'sd0, 8'h00));
        send_item(make_step(4'sd7, -4'sd8, 8'hFF));
        send_item(make_step(-4'sd8, 4'sd7, 8'h5A));
        send_item(make_load(7, 7, 8'hAA));
        send_item(make_load(3, 5, 8'h55));
        it = random_noise();
        it.opcode = ghl_pkg::OP_SPARE;
        send_item(it);
        it.opcode = ghl_pkg::OP_UNIFORM;
        send_item(it);
        send_item(make_step(-4'sd1, 4'sd1, 8'h00));
        drain();

        // correct = 0 weights only the cells whose color does not match
        write_reg(ghl_pkg::REG_CORRECT, 17'd0);
        write_reg(ghl_pkg::REG_MOVE, 17'h1FFFF);
        send_item(make_step(4'sd1, 4'sd2, 8'h00));
        send_item(make_step(4'sd3, 4'sd4, 8'h12));
        it.opcode = ghl_pkg::OP_UNIFORM;
        send_item(it);
        drain();
        // a perfect sensor and a color absent from the map zero the sum
        write_reg(ghl_pkg::REG_CORRECT, 17'd65536);
        write_reg(ghl_pkg::REG_MOVE, 17'd0);
        send_item(make_step(4'sd2, 4'sd3, 8'hFF));
        send_item(make_step(4'sd1, 4'sd1, 8'h77));
        drain();

        // random phases, each under its own register pair
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(ghl_pkg::REG_CORRECT, (ph < 6) ? reg_set[ph] : 17'($urandom));
            write_reg(ghl_pkg::REG_MOVE, (ph < 6) ? reg_set[5 - ph] : 17'($urandom));
            if (ph == 3) begin
                hold_sink <= 1'b1;
            end
            for (int n = 0; n < 28; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    send_item(make_step(4'($urandom), 4'($urandom),
                                        ($urandom_range(0, 3) == 0) ?
                                        8'($urandom) : {8{$urandom_range(0, 1) == 1}}));
                end else if (pick < 80) begin
                    send_item(make_load($urandom_range(0, ROWS - 1),
                                        $urandom_range(0, COLS - 1),
                                        ($urandom_range(0, 1) == 1) ?
                                        8'($urandom) : {8{$urandom_range(0, 1) == 1}}));
                end else if (pick < 90) begin
                    it = random_noise();
                    it.opcode = ghl_pkg::OP_UNIFORM;
                    send_item(it);
                end else begin
                    // noise, including off-grid loads and the unused opcode
                    it = random_noise();
                    if (it.opcode == ghl_pkg::OP_STEP) it.opcode = ghl_pkg::OP_SPARE;
                    send_item(it);
                end
                if (n == 14 && ph == 5) drain();
            end
            drain();
        end
        hold_sink <= 1'b0;
        drain();

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/ghl_pkg.sv
rtl/ghl_if.sv
rtl/ghl_ram.sv
rtl/ghl_div.sv
rtl/ghl_ctrl.sv
rtl/ghl_dp.sv
rtl/grid_histogram_localizer.sv
tb/sv/ghl_checker.sv
tb/sv/testbench.sv
